/* hw/rtl/hsf_pkg.sv */
package hsf_pkg;

    // Width of the configuration data port and of both limit registers.
    localparam int CFG_W = 11;

    // Register map of the configuration port.
    typedef enum logic [0:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd256;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd256;

    // Per-sample control flags from the raster counters.
    typedef struct packed {
        logic emit;   // window complete: not in first row or first column
        logic keep;   // top-left of window sits on even column and even row
    } win_tag_t;

endpackage

/* hw/rtl/haar_subband_filter_2x2.sv */
// One scale of an undecimated 2x2 Haar decomposition over a raster stream.
//
// Input channel (sample_valid/sample_ready): one sample per transaction, in
// raster order over a region line_width wide and frame_height high. Output
// channel (result_valid/result_ready): one transaction per complete 2x2
// window, carrying ll_sum (LL times 4), lh/hl/hh differences (band times 2),
// the window's top-left column and row, and keep_next_scale for even/even.
// The first row and first column of each frame produce no transaction.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 line
// width, 1 frame height); write only while no transaction is in flight.
// Throughput: one sample per cycle while results are taken, set by the line
// store, which reads and rewrites the same entry through its single port.
// Pipeline: the accepting edge reads the line store and loads the middle
// stage; once the output register is free, the add/subtract results of a
// complete window load into it and result_valid rises.
// Receiver stall: the output register holds; the middle stage holds one more
// sample, then sample_ready drops until result_ready returns.
// Reset: counters go to row 0 column 0, limits to 256, no result pending.
// The line store has no clearing pass; each frame's first row fills it.
module haar_subband_filter_2x2 #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int ROW_W      = $clog2(MAX_HEIGHT),
    localparam int SUM_W      = SAMPLE_BITS + 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [hsf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [SUM_W-1:0]          ll_sum,
    output logic signed [SUM_W-1:0]   lh_diff,
    output logic signed [SUM_W-1:0]   hl_diff,
    output logic signed [SUM_W-1:0]   hh_diff,
    output logic [COL_W-1:0]          out_col,
    output logic [ROW_W-1:0]          out_row,
    output logic                      keep_next_scale
);

    logic                   in_accept;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    hsf_pkg::win_tag_t      tag;
    logic [SAMPLE_BITS-1:0] above;

    assign in_accept = sample_valid && sample_ready;

    // Raster position and limits; advance once per accepted sample.
    hsf_raster_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .col       (col),
        .row       (row),
        .tag       (tag)
    );

    // Previous row: fetch the sample above and drop the new one in its place.
    hsf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .clk   (clk),
        .en    (in_accept),
        .addr  (col),
        .wdata (sample),
        .rdata (above)
    );

    // Window sums and the output register.
    hsf_butterfly #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_W       (COL_W),
        .ROW_W       (ROW_W),
        .SUM_W       (SUM_W)
    ) u_bfly (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (in_accept),
        .sample          (sample),
        .col             (col),
        .row             (row),
        .tag             (tag),
        .above           (above),
        .load_ready      (sample_ready),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .ll_sum          (ll_sum),
        .lh_diff         (lh_diff),
        .hl_diff         (hl_diff),
        .hh_diff         (hh_diff),
        .out_col         (out_col),
        .out_row         (out_row),
        .keep_next_scale (keep_next_scale)
    );

endmodule

/* hw/rtl/hsf_raster_ctrl.sv */
module hsf_raster_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [hsf_pkg::CFG_W-1:0] cfg_data,
    input  logic                     advance,
    output logic [COL_W-1:0]         col,
    output logic [ROW_W-1:0]         row,
    output hsf_pkg::win_tag_t        tag
);

    localparam int WL_W = (COL_W + 1 > hsf_pkg::CFG_W) ? COL_W + 1 : hsf_pkg::CFG_W;
    localparam int HL_W = (ROW_W + 1 > hsf_pkg::CFG_W) ? ROW_W + 1 : hsf_pkg::CFG_W;

    logic [hsf_pkg::CFG_W-1:0] line_width_reg;
    logic [hsf_pkg::CFG_W-1:0] frame_height_reg;
    logic [COL_W-1:0]          col_count_reg;
    logic [COL_W-1:0]          col_count_next;
    logic [ROW_W-1:0]          row_count_reg;
    logic [ROW_W-1:0]          row_count_next;

    logic [WL_W-1:0]  w_raw;
    logic [WL_W-1:0]  w_sat;
    logic [HL_W-1:0]  h_raw;
    logic [HL_W-1:0]  h_sat;
    logic [COL_W:0]   w_lim;
    logic [COL_W:0]   w_last;
    logic [ROW_W:0]   h_lim;
    logic [COL_W-1:0] col_eff;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= hsf_pkg::LINE_WIDTH_RST;
            frame_height_reg <= hsf_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (hsf_pkg::cfg_reg_t'(cfg_index))
                hsf_pkg::REG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                hsf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate limits to 2..MAX.
    always_comb
    begin
        w_raw = WL_W'(line_width_reg);
        h_raw = HL_W'(frame_height_reg);
        if (w_raw < WL_W'(2))
            w_sat = WL_W'(2);
        else if (w_raw > WL_W'(MAX_WIDTH))
            w_sat = WL_W'(MAX_WIDTH);
        else
            w_sat = w_raw;
        if (h_raw < HL_W'(2))
            h_sat = HL_W'(2);
        else if (h_raw > HL_W'(MAX_HEIGHT))
            h_sat = HL_W'(MAX_HEIGHT);
        else
            h_sat = h_raw;
        w_lim  = w_sat[COL_W:0];
        h_lim  = h_sat[ROW_W:0];
        w_last = w_lim - 1'b1;
    end

    // Pull the column back inside a width that shrank; step the raster position.
    always_comb
    begin
        if ({1'b0, col_count_reg} >= w_lim)
            col_eff = w_last[COL_W-1:0];
        else
            col_eff = col_count_reg;
        col_inc = {1'b0, col_eff} + 1'b1;
        row_inc = {1'b0, row_count_reg} + 1'b1;
        if (col_inc >= w_lim)
        begin
            col_count_next = '0;
            if (row_inc >= h_lim)
                row_count_next = '0;
            else
                row_count_next = row_inc[ROW_W-1:0];
        end
        else
        begin
            col_count_next = col_inc[COL_W-1:0];
            row_count_next = row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (advance)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    assign col = col_eff;
    assign row = row_count_reg;
    // Top-left sits one column left and one row up: even there means odd here.
    assign tag.emit = (col_eff != '0) && (row_count_reg != '0);
    assign tag.keep = col_eff[0] & row_count_reg[0];

endmodule

/* hw/rtl/hsf_line_store.sv */
module hsf_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] row_store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Read old contents and replace them at the same address in the same cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg           <= row_store_mem[addr];
            row_store_mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/hsf_butterfly.sv */
module hsf_butterfly #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W       = 10,
    parameter int ROW_W       = 10,
    parameter int SUM_W       = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [SAMPLE_BITS-1:0]  sample,
    input  logic [COL_W-1:0]        col,
    input  logic [ROW_W-1:0]        row,
    input  hsf_pkg::win_tag_t       tag,
    input  logic [SAMPLE_BITS-1:0]  above,
    output logic                    load_ready,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [SUM_W-1:0]        ll_sum,
    output logic signed [SUM_W-1:0] lh_diff,
    output logic signed [SUM_W-1:0] hl_diff,
    output logic signed [SUM_W-1:0] hh_diff,
    output logic [COL_W-1:0]        out_col,
    output logic [ROW_W-1:0]        out_row,
    output logic                    keep_next_scale
);

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    hsf_pkg::win_tag_t      s1_tag_reg;
    logic [SAMPLE_BITS-1:0] above_left_reg;
    logic [SAMPLE_BITS-1:0] left_reg;

    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [SUM_W-1:0]        ll_reg;
    logic signed [SUM_W-1:0] lh_reg;
    logic signed [SUM_W-1:0] hl_reg;
    logic signed [SUM_W-1:0] hh_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic                    keep_reg;

    logic                    s1_adv;
    logic signed [SUM_W-1:0] a_s;
    logic signed [SUM_W-1:0] b_s;
    logic signed [SUM_W-1:0] d_s;
    logic signed [SUM_W-1:0] e_s;
    logic signed [SUM_W-1:0] top_sum;
    logic signed [SUM_W-1:0] bot_sum;
    logic signed [SUM_W-1:0] top_dif;
    logic signed [SUM_W-1:0] bot_dif;

    assign s1_adv     = s1_valid_reg && (!result_valid_reg || result_ready);
    assign load_ready = !s1_valid_reg || s1_adv;

    // Window operands: a top-left, b top-right, d bottom-left, e bottom-right.
    always_comb
    begin
        a_s     = $signed({2'b00, above_left_reg});
        b_s     = $signed({2'b00, above});
        d_s     = $signed({2'b00, left_reg});
        e_s     = $signed({2'b00, s1_sample_reg});
        top_sum = a_s + b_s;
        bot_sum = d_s + e_s;
        top_dif = a_s - b_s;
        bot_dif = d_s - e_s;
    end

    always_comb
    begin
        if (s1_adv && s1_tag_reg.emit)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            above_left_reg   <= '0;
            left_reg         <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (load)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                above_left_reg <= above;
                left_reg       <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_sample_reg <= sample;
            s1_col_reg    <= col;
            s1_row_reg    <= row;
            s1_tag_reg    <= tag;
        end
        if (s1_adv && s1_tag_reg.emit)
        begin
            ll_reg   <= $unsigned(top_sum + bot_sum);
            lh_reg   <= top_dif + bot_dif;
            hl_reg   <= top_sum - bot_sum;
            hh_reg   <= top_dif - bot_dif;
            col_reg  <= s1_col_reg - 1'b1;
            row_reg  <= s1_row_reg - 1'b1;
            keep_reg <= s1_tag_reg.keep;
        end
    end

    assign result_valid    = result_valid_reg;
    assign ll_sum          = ll_reg;
    assign lh_diff         = lh_reg;
    assign hl_diff         = hl_reg;
    assign hh_diff         = hh_reg;
    assign out_col         = col_reg;
    assign out_row         = row_reg;
    assign keep_next_scale = keep_reg;

endmodule

/* hw/rtl/hsf_checker.sv */
module hsf_checker #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10,
    parameter int SUM_W = 18
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    sample_ready,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [SUM_W-1:0]        ll_sum,
    input logic signed [SUM_W-1:0] lh_diff,
    input logic signed [SUM_W-1:0] hl_diff,
    input logic signed [SUM_W-1:0] hh_diff,
    input logic [COL_W-1:0]        out_col,
    input logic [ROW_W-1:0]        out_row,
    input logic                    keep_next_scale
);

    // Hold a pending result until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transaction");

    // Input stalls only when the output register is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("input stalled without output backpressure");

    // Keep flag marks even column and even row only.
    a_keep_even: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && keep_next_scale |-> !out_col[0] && !out_row[0])
        else $error("keep flag on odd position");

    // Sum and differences differ by even amounts: same parity.
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (ll_sum[0] == lh_diff[0]) && (ll_sum[0] == hl_diff[0])
                         && (ll_sum[0] == hh_diff[0]))
        else $error("band parity mismatch");

endmodule

bind haar_subband_filter_2x2 hsf_checker #(
    .COL_W (COL_W),
    .ROW_W (ROW_W),
    .SUM_W (SUM_W)
) u_hsf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_ready    (sample_ready),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .ll_sum          (ll_sum),
    .lh_diff         (lh_diff),
    .hl_diff         (hl_diff),
    .hh_diff         (hh_diff),
    .out_col         (out_col),
    .out_row         (out_row),
    .keep_next_scale (keep_next_scale)
);

/* tb/haar_subband_filter_2x2_checker.sv */
module haar_subband_filter_2x2_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [hsf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        sample_valid,
    input  logic                        sample_ready,
    input  logic [15:0]                 sample,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [17:0]                 ll_sum,
    input  logic signed [17:0]          lh_diff,
    input  logic signed [17:0]          hl_diff,
    input  logic signed [17:0]          hh_diff,
    input  logic [9:0]                  out_col,
    input  logic [9:0]                  out_row,
    input  logic                        keep_next_scale,
    output int                          fail_count,
    output int                          pending,
    output int                          windows_checked,
    output logic                        at_origin
);
    import hsf_pkg::*;

    typedef struct packed {
        logic [17:0]        ll;
        logic signed [17:0] lh;
        logic signed [17:0] hl;
        logic signed [17:0] hh;
        logic [9:0]         col;
        logic [9:0]         row;
        logic               keep;
    } haar_window_t;

    haar_window_t     window_queue [$];
    logic [15:0]      line_buf [0:1023];
    logic [15:0]      up_left;
    logic [15:0]      left_px;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    function automatic int unsigned span_limit(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > 1024)
            return 1024;
        return v;
    endfunction

    // Advance the raster position by one sample and queue the window it closes.
    task automatic predict_window(input logic [15:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int           a;
        int           b;
        int           d;
        int           e;
        logic [15:0]  up;
        haar_window_t win;
        w = span_limit(width_reg);
        h = span_limit(height_reg);
        c = col_pos;
        if (c >= w)
            c = w - 1;
        up = line_buf[c];
        if (c >= 1 && row_pos >= 1)
        begin
            a = up_left;
            b = up;
            d = left_px;
            e = px;
            win.ll   = 18'(a + b + d + e);
            win.lh   = 18'(a - b + d - e);
            win.hl   = 18'(a + b - d - e);
            win.hh   = 18'(a - b - d + e);
            win.col  = 10'(c - 1);
            win.row  = 10'(row_pos - 1);
            win.keep = !win.col[0] && !win.row[0];
            window_queue.push_back(win);
        end
        up_left     = up;
        line_buf[c] = px;
        left_px     = px;
        c++;
        if (c >= w)
        begin
            c = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
        col_pos = c;
    endtask

    task automatic check_window();
        haar_window_t want;
        haar_window_t got;
        got.ll   = ll_sum;
        got.lh   = lh_diff;
        got.hl   = hl_diff;
        got.hh   = hh_diff;
        got.col  = out_col;
        got.row  = out_row;
        got.keep = keep_next_scale;
        windows_checked++;
        if (window_queue.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: unexpected window at col %0d row %0d", out_col, out_row);
        end
        else
        begin
            want = window_queue.pop_front();
            if (want != got)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("ERROR: window mismatch, expected ll=%0d lh=%0d hl=%0d hh=%0d",
                             want.ll, want.lh, want.hl, want.hh,
                             " col=%0d row=%0d keep=%0b", want.col, want.row, want.keep);
                    $display("       got               ll=%0d lh=%0d hl=%0d hh=%0d",
                             got.ll, got.lh, got.hl, got.hh,
                             " col=%0d row=%0d keep=%0b", got.col, got.row, got.keep);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_queue.delete();
            up_left         = '0;
            left_px         = '0;
            col_pos         = 0;
            row_pos         = 0;
            width_reg       = LINE_WIDTH_RST;
            height_reg      = FRAME_HEIGHT_RST;
            fail_count      = 0;
            windows_checked = 0;
            pending         = 0;
            at_origin       = 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LINE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (result_valid && result_ready)
                check_window();
            if (sample_valid && sample_ready)
                predict_window(sample);
            pending   = window_queue.size();
            at_origin = (col_pos == 0) && (row_pos == 0);
        end
    end

endmodule

/* tb/haar_subband_filter_2x2_tb.sv */
module haar_subband_filter_2x2_tb;
    import hsf_pkg::*;

    // Cycles with no transaction on any port before the run is declared hung.
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_SAMPLES = 200;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_we       = 1'b0;
    logic             cfg_index    = 1'b0;
    logic [CFG_W-1:0] cfg_data     = '0;
    logic             sample_valid = 1'b0;
    logic [15:0]      sample       = '0;
    logic             result_ready = 1'b0;

    logic               sample_ready;
    logic               result_valid;
    logic [17:0]        ll_sum;
    logic signed [17:0] lh_diff;
    logic signed [17:0] hl_diff;
    logic signed [17:0] hh_diff;
    logic [9:0]         out_col;
    logic [9:0]         out_row;
    logic               keep_next_scale;

    int   fail_count;
    int   pending;
    int   windows_checked;
    logic at_origin;

    int samples_sent = 0;
    int limit_writes = 0;
    int idle_cycles  = 0;
    int rx_hold      = 0;
    bit tx_gaps      = 1'b0;
    bit rx_stalls    = 1'b0;

    // Mirror of the limit registers, used to decide when a width change is safe.
    logic [CFG_W-1:0] width_reg  = LINE_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;

    // Opening pattern, three samples per row over a five-row frame: windows of
    // all-ones and all-zeros samples drive every band to its positive extreme
    // and hl to its negative one; the frame's first row and column produce nothing.
    // The tail starts a new frame with alternating and single-bit levels.
    logic [15:0] corner_samples [0:18] = '{
        16'hFFFF, 16'hFFFF, 16'h0000,
        16'hFFFF, 16'hFFFF, 16'h0000,
        16'h0000, 16'h0000, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'hFFFF, 16'h0000,
        16'h5555, 16'hAAAA, 16'h8000, 16'h0001
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    haar_subband_filter_2x2 dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .ll_sum          (ll_sum),
        .lh_diff         (lh_diff),
        .hl_diff         (hl_diff),
        .hh_diff         (hh_diff),
        .out_col         (out_col),
        .out_row         (out_row),
        .keep_next_scale (keep_next_scale)
    );

    haar_subband_filter_2x2_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .ll_sum          (ll_sum),
        .lh_diff         (lh_diff),
        .hl_diff         (hl_diff),
        .hh_diff         (hh_diff),
        .out_col         (out_col),
        .out_row         (out_row),
        .keep_next_scale (keep_next_scale),
        .fail_count      (fail_count),
        .pending         (pending),
        .windows_checked (windows_checked),
        .at_origin       (at_origin)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    function automatic int unsigned active_span(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > 1024)
            return 1024;
        return v;
    endfunction

    // Receiver: stall result_ready for random stretches while stalls are on.
    always @(negedge clk)
    begin
        if (rx_hold == 0 && rx_stalls && $urandom_range(99, 0) < 25)
            rx_hold = gap_length();
        if (rx_hold > 0)
        begin
            result_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Watchdog: any transaction or register write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one sample and hold it until the transaction completes. Valid
    // stays high on return, so back-to-back samples keep it asserted.
    task automatic send_sample(input logic [15:0] px);
        if (tx_gaps && $urandom_range(99, 0) < 30)
        begin
            sample_valid <= 1'b0;
            repeat (gap_length()) @(negedge clk);
        end
        sample       <= px;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        @(negedge clk);
        samples_sent++;
    endtask

    // Stream random pixel levels, with zero, full scale and single bits mixed in.
    task automatic send_burst(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                send_sample(16'($urandom));
            else if (pick < 80)
                send_sample(16'h0000);
            else if (pick < 90)
                send_sample(16'hFFFF);
            else
                send_sample(16'(1 << $urandom_range(15, 0)));
        end
    endtask

    // Drop valid, drain every expected window, then let samples that close
    // no window clear the pipeline.
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_LINE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        limit_writes++;
    endtask

    // Reach row 0 column 0 quickly: shrink the frame to two rows, then pad.
    task automatic seek_frame_origin();
        if (!at_origin)
        begin
            settle();
            write_limit(REG_FRAME_HEIGHT, 11'($urandom_range(2, 0)));
            while (!at_origin)
                send_sample(16'($urandom));
            settle();
        end
    endtask

    // A wider line is only safe at the start of a frame: otherwise the next
    // row would read line store entries that were never written. Narrowing
    // and any height change are fine mid-frame and are left there on purpose.
    task automatic change_limits(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        if (active_span(w) > active_span(width_reg))
            seek_frame_origin();
        write_limit(REG_LINE_WIDTH, w);
        write_limit(REG_FRAME_HEIGHT, h);
    endtask

    initial
    begin
        int               n;
        int               pick;
        int               random_start;
        logic [CFG_W-1:0] w_new;
        logic [CFG_W-1:0] h_new;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners with no idling on either side.
        write_limit(REG_LINE_WIDTH, 11'd3);
        write_limit(REG_FRAME_HEIGHT, 11'd5);
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);

        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;

        // Above-range width that clamps to the widest line, with a below-range
        // height: the first row wraps only at the clamped width, and a few
        // windows close at the left of the second row. Then a below-range
        // width wraps the row mid-frame.
        change_limits(11'd2047, 11'd0);
        send_burst(1024 + 6);
        settle();
        write_limit(REG_LINE_WIDTH, 11'd0);
        send_burst(12);

        // Tall frame on the narrowest line, then above-range and
        // below-range heights while deep in the frame.
        change_limits(11'd1, 11'd1024);
        send_burst(60);
        settle();
        write_limit(REG_FRAME_HEIGHT, 11'd2047);
        send_burst(10);
        settle();
        write_limit(REG_FRAME_HEIGHT, 11'd1);
        send_burst(8);

        // Random phases: small geometries mostly, random idling per phase.
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_SAMPLES)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 6)
                w_new = 11'($urandom_range(1, 0));
            else if (pick < 60)
                w_new = 11'($urandom_range(6, 2));
            else if (pick < 92)
                w_new = 11'($urandom_range(20, 7));
            else
                w_new = 11'($urandom_range(72, 21));
            pick = $urandom_range(99, 0);
            if (pick < 8)
                h_new = 11'($urandom_range(1, 0));
            else if (pick < 65)
                h_new = 11'($urandom_range(6, 2));
            else if (pick < 95)
                h_new = 11'($urandom_range(16, 7));
            else
                h_new = 11'($urandom_range(2047, 1025));
            change_limits(w_new, h_new);
            tx_gaps   = ($urandom_range(99, 0) < 75);
            rx_stalls = ($urandom_range(99, 0) < 75);
            n = active_span(w_new) * $urandom_range(4, 1)
                + $urandom_range(active_span(w_new), 0);
            if (n > RANDOM_SAMPLES - (samples_sent - random_start))
                n = RANDOM_SAMPLES - (samples_sent - random_start);
            send_burst(n);
        end

        // Drain, then allow a margin for any stray result.
        settle();
        repeat (8) @(negedge clk);

        $display("Sent %0d samples and checked %0d windows over %0d limit writes,",
                 samples_sent, windows_checked, limit_writes);
        $display("including clamped limits, mid-frame changes and a full-width line.");
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
